/* src/mvir_pkg.sv */
// ----------------------------------------------------------------------------
// mvir_pkg
// Shared types, codes and helpers for the meshlet vertex index remap block.
// ----------------------------------------------------------------------------
package mvir_pkg;

  // result field widths
  localparam int KIND_W   = 2;
  localparam int UV_W     = 24;
  localparam int LOCAL_W  = 6;
  localparam int BEGIN_W  = 32;
  localparam int VCOUNT_W = 7;
  localparam int PCOUNT_W = 16;
  localparam int OUT_DATA_W = 120;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_UNIQUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CORNER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

  // result queue depth and pointer widths
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [UV_W-1:0]     unique_vertex;
    logic [LOCAL_W-1:0]  local_index;
    logic [BEGIN_W-1:0]  vert_base;
    logic [VCOUNT_W-1:0] vertex_count;
    logic [BEGIN_W-1:0]  prim_begin;
    logic [PCOUNT_W-1:0] prim_count;
    logic                overflow;
    logic                last;
  } result_t;

  // table lookup outcome for the current corner
  typedef struct packed {
    logic                is_new;
    logic                overflow;
    logic [LOCAL_W-1:0]  local_index;
    logic [VCOUNT_W-1:0] vertex_count;
  } lookup_t;

  // saturating increment of a running total
  function automatic logic [BEGIN_W-1:0] sat_inc32(input logic [BEGIN_W-1:0] v);
    sat_inc32 = (v == {BEGIN_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // pack the non-kind, non-last fields into tdata, lowest field first
  function automatic logic [OUT_DATA_W-1:0] pack_data(input result_t r);
    pack_data = {2'b00, r.overflow, r.prim_count, r.prim_begin, r.vertex_count,
                 r.vert_base, r.local_index, r.unique_vertex};
  endfunction

endpackage

/* src/mvir_table.sv */
// ----------------------------------------------------------------------------
// mvir_table
// Per-meshlet vertex tag table with a parallel compare and local index count.
// ----------------------------------------------------------------------------
module mvir_table
  import mvir_pkg::*;
#(
  parameter int MAX_LOCAL_VERTS   = 64,
  parameter int VERTEX_INDEX_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [VERTEX_INDEX_BITS-1:0] global_vertex,
  input  logic                         meshlet_end,
  output lookup_t                      lookup
);

  localparam int SLOT_W = (MAX_LOCAL_VERTS > 1) ? $clog2(MAX_LOCAL_VERTS) : 1;
  localparam int CNT_W  = $clog2(MAX_LOCAL_VERTS + 1);

  logic [VERTEX_INDEX_BITS-1:0] tags [MAX_LOCAL_VERTS];
  logic [MAX_LOCAL_VERTS-1:0]   seen_valid;
  logic [CNT_W-1:0]             next_local;

  logic [MAX_LOCAL_VERTS-1:0] hit;
  logic [SLOT_W-1:0]          hit_slot;
  logic [SLOT_W-1:0]          slot;
  logic                       found;
  logic                       full;
  logic                       is_new;

  // parallel tag compare; valid tags are unique, so an OR encoder suffices
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_LOCAL_VERTS; i++) begin
      hit[i] = seen_valid[i] && (tags[i] == global_vertex);
      hit_slot = hit_slot | (SLOT_W'(i) & {SLOT_W{hit[i]}});
    end
  end

  assign found  = |hit;
  assign full   = (next_local == CNT_W'(MAX_LOCAL_VERTS));
  assign is_new = !found && !full;

  always_comb begin
    if (found) begin
      slot = hit_slot;
    end else if (is_new) begin
      slot = next_local[SLOT_W-1:0];
    end else begin
      slot = '0;
    end
  end

  assign lookup.is_new       = is_new;
  assign lookup.overflow     = !found && full;
  assign lookup.local_index  = LOCAL_W'(slot);
  assign lookup.vertex_count = VCOUNT_W'(next_local + CNT_W'(is_new));

  // tag storage, written only on a new vertex
  always_ff @(posedge clk) begin
    if (fire && is_new) begin
      tags[slot] <= global_vertex;
    end
  end

  // valid bits and fill count; meshlet end clears the table
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid <= '0;
      next_local <= '0;
    end else if (fire) begin
      if (meshlet_end) begin
        seen_valid <= '0;
        next_local <= '0;
      end else if (is_new) begin
        seen_valid[slot] <= 1'b1;
        next_local       <= next_local + 1'b1;
      end
    end
  end

  // table is cleared after a meshlet end
  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    fire && meshlet_end |=> (next_local == '0) && (seen_valid == '0))
    else $error("table not cleared after meshlet end");

  // a new vertex takes exactly one slot
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fire && is_new && !meshlet_end |=> next_local == $past(next_local) + 1'b1)
    else $error("fill count did not advance on new vertex");

endmodule

/* src/mvir_outq.sv */
// ----------------------------------------------------------------------------
// mvir_outq
// Small result queue: takes up to three items per cycle, delivers one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module mvir_outq
  import mvir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_n,
  input  result_t               push_data [3],
  output logic [Q_LVL_W-1:0]    level,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output result_t               head
);

  result_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wp;
  logic [Q_PTR_W-1:0]  rp;

  assign m_tvalid = (level != '0);
  assign pop      = m_tvalid && m_tready;
  assign head     = mem[rp];

  // write up to three items at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(push_n)) begin
        mem[wp + Q_PTR_W'(k)] <= push_data[k];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + Q_PTR_W'(push_n);
      rp    <= rp + Q_PTR_W'(pop);
      level <= level - Q_LVL_W'(pop) + Q_LVL_W'(push_n);
    end
  end

  // a push never overruns the queue
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (level - Q_LVL_W'(pop) + Q_LVL_W'(push_n)) <= Q_LVL_W'(Q_DEPTH))
    else $error("result queue overrun");

endmodule

/* src/meshlet_vertex_index_remap_top.sv */
// ----------------------------------------------------------------------------
// meshlet_vertex_index_remap_top
// Remaps global vertex indices to meshlet-local indices and emits meshlet
// records.
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  tdata: global_vertex; tlast: meshlet_end
// m        out  m_tvalid/m_tready  tdata: result fields; tuser: kind; tlast: last
//
// Each corner is processed from its input register and yields one to three
// result items; the result queue delivers one item per cycle while m_tready
// is high, and a corner is taken only when the queue has room for three.
// Reset clears the valid bits, counters and queue at once; no clearing pass.
// Output stalls back up through the queue into the input register.
// ----------------------------------------------------------------------------
module meshlet_vertex_index_remap_top
  import mvir_pkg::*;
#(
  parameter int MAX_LOCAL_VERTS   = 64,
  parameter int VERTEX_INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [VERTEX_INDEX_BITS-1:0] global_vertex
  input  logic [((VERTEX_INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                  s_tlast,   // meshlet_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // unique_vertex[23:0] local_index[29:24] vert_base[61:30]
  // vertex_count[68:62] prim_begin[100:69] prim_count[116:101] overflow[117]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]     m_tuser,   // kind
  output logic                  m_tlast    // last
);

  // input register
  logic                         stage_valid;
  logic [VERTEX_INDEX_BITS-1:0] stage_gv;
  logic                         stage_end;

  logic [Q_LVL_W-1:0] q_level;
  logic               q_pop;
  logic               space;
  logic               fire;
  lookup_t            lookup;
  result_t            head;

  // running totals and per-meshlet primitive tracking
  logic [BEGIN_W-1:0]  unique_total;
  logic [BEGIN_W-1:0]  corner_total;
  logic [BEGIN_W-1:0]  meshlet_vertex_start;
  logic [BEGIN_W-1:0]  meshlet_corner_start;
  logic [PCOUNT_W-1:0] prim_cnt;
  logic [1:0]          prim_res;

  logic [BEGIN_W-1:0]  unique_total_next;
  logic [BEGIN_W-1:0]  corner_total_next;
  logic [PCOUNT_W-1:0] prim_cnt_next;
  logic [1:0]          prim_res_next;

  result_t    res [3];
  result_t    r_unique;
  result_t    r_corner;
  result_t    r_record;
  logic [1:0] res_n;
  logic [1:0] push_n;

  // room for three more items once this cycle's pop is counted
  assign space    = (q_level <= Q_LVL_W'(1)) || ((q_level == Q_LVL_W'(2)) && q_pop);
  assign fire     = stage_valid && space;
  assign s_tready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_gv  <= s_tdata[VERTEX_INDEX_BITS-1:0];
      stage_end <= s_tlast;
    end
  end

  mvir_table #(
    .MAX_LOCAL_VERTS  (MAX_LOCAL_VERTS),
    .VERTEX_INDEX_BITS(VERTEX_INDEX_BITS)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .global_vertex(stage_gv),
    .meshlet_end  (stage_end),
    .lookup       (lookup)
  );

  // totals after this corner; corner count /3 kept as count plus residue
  always_comb begin
    unique_total_next = lookup.is_new ? sat_inc32(unique_total) : unique_total;
    corner_total_next = sat_inc32(corner_total);
    prim_cnt_next     = prim_cnt;
    prim_res_next     = prim_res;
    if (corner_total != {BEGIN_W{1'b1}}) begin
      if (prim_res == 2'd2) begin
        prim_res_next = 2'd0;
        prim_cnt_next = (prim_cnt == {PCOUNT_W{1'b1}}) ? prim_cnt : prim_cnt + 1'b1;
      end else begin
        prim_res_next = prim_res + 1'b1;
      end
    end
  end

  // build the results of this corner
  always_comb begin
    r_unique               = '0;
    r_unique.kind          = KIND_UNIQUE;
    r_unique.unique_vertex = UV_W'(stage_gv);

    r_corner               = '0;
    r_corner.kind          = KIND_CORNER;
    r_corner.local_index   = lookup.local_index;
    r_corner.overflow      = lookup.overflow;
    r_corner.last          = !stage_end;

    r_record               = '0;
    r_record.kind          = KIND_RECORD;
    r_record.vert_base     = meshlet_vertex_start;
    r_record.vertex_count  = lookup.vertex_count;
    r_record.prim_begin    = meshlet_corner_start;
    r_record.prim_count    = prim_cnt_next;
    r_record.last          = 1'b1;

    if (lookup.is_new) begin
      res[0] = r_unique;
      res[1] = r_corner;
      res[2] = r_record;
      res_n  = stage_end ? 2'd3 : 2'd2;
    end else begin
      res[0] = r_corner;
      res[1] = r_record;
      res[2] = r_record;
      res_n  = stage_end ? 2'd2 : 2'd1;
    end
  end

  assign push_n = fire ? res_n : 2'd0;

  // state update per processed corner
  always_ff @(posedge clk) begin
    if (rst) begin
      unique_total         <= '0;
      corner_total         <= '0;
      meshlet_vertex_start <= '0;
      meshlet_corner_start <= '0;
      prim_cnt             <= '0;
      prim_res             <= '0;
    end else if (fire) begin
      unique_total <= unique_total_next;
      corner_total <= corner_total_next;
      if (stage_end) begin
        meshlet_vertex_start <= unique_total_next;
        meshlet_corner_start <= corner_total_next;
        prim_cnt             <= '0;
        prim_res             <= '0;
      end else begin
        prim_cnt <= prim_cnt_next;
        prim_res <= prim_res_next;
      end
    end
  end

  mvir_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_data(res),
    .level    (q_level),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = pack_data(head);
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  // a unique-vertex item is always followed by its corner item
  a_unique_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_UNIQUE) |-> !m_tlast)
    else $error("unique vertex item marked last");

  // overflow corners never enter the table
  a_ovf_not_new: assert property (@(posedge clk) disable iff (rst)
    fire && lookup.overflow |-> !lookup.is_new && (lookup.local_index == '0))
    else $error("overflow corner entered table");

endmodule
